>>> rtl/tdh_pkg.sv
// Shared constants and types for the timer deadline heap.
package tdh_pkg;

  localparam int unsigned HeapDepth = 32;
  localparam int unsigned TimeBits  = 48;
  localparam int unsigned TaskBits  = 16;
  localparam int unsigned StampBits = 16;
  localparam int unsigned WaitBits  = 32;
  localparam int unsigned FireCap   = 32;

  localparam logic OpAdd  = 1'b0;
  localparam logic OpFire = 1'b1;

  localparam logic [WaitBits-1:0] WaitEmpty = '1;
  localparam logic [WaitBits-1:0] WaitMax   = {1'b0, {(WaitBits-1){1'b1}}};

  typedef struct packed {
    logic [TaskBits-1:0] ready_task;
    logic                fired;
    logic                last;
    logic [WaitBits-1:0] wait_ms;
    logic                overflow;
  } tdh_out_t;

endpackage

>>> rtl/tdh_if.sv
// Valid/ready channel interfaces for the timer deadline heap.
interface tdh_in_if #(
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned TASK_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [TIME_BITS-1:0] deadline;
  logic [TASK_BITS-1:0] task_id;
  logic [TIME_BITS-1:0] current_time;
  modport source (output valid, operation, deadline, task_id, current_time, input ready);
  modport sink   (input valid, operation, deadline, task_id, current_time, output ready);
endinterface

interface tdh_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] ready_task;
  logic        fired;
  logic        last;
  logic [31:0] wait_ms;
  logic        overflow;
  modport source (output valid, ready_task, fired, last, wait_ms, overflow, input ready);
  modport sink   (input valid, ready_task, fired, last, wait_ms, overflow, output ready);
endinterface

>>> rtl/timer_deadline_heap_core.sv
// Timer queue kept as a binary min-heap in one synchronous memory.
//
// The heap lives in a single memory of HEAP_DEPTH words with a registered
// read, and a copy of the root sits in a register so the wait time is known
// at once. Items are taken one at a time; the next item is accepted only
// after every result beat of the current one has left. An add writes the new
// entry at the end and lets it rise one level at a time (read the parent,
// compare, write one slot), for at most log2(HEAP_DEPTH) levels; an add to a
// full heap only reports overflow. A fire that expires nothing only reports
// the wait. Otherwise a fire pops each expired entry in turn, and the former
// last entry sinks from the root (read two children, compare, write one
// slot), except after a pop that empties the heap. A result beat that waits
// on the sink holds the next step.
module timer_deadline_heap_core #(
  parameter int unsigned HEAP_DEPTH = tdh_pkg::HeapDepth,
  parameter int unsigned TIME_BITS  = tdh_pkg::TimeBits,
  parameter int unsigned TASK_BITS  = tdh_pkg::TaskBits
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  tdh_in_if.sink   in_i,
  tdh_out_if.source out_o
);
  import tdh_pkg::*;

  localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned FW = $clog2(FireCap + 1);
  localparam int unsigned DW = (TIME_BITS > WaitBits) ? TIME_BITS : WaitBits;

  typedef struct packed {
    logic [TIME_BITS-1:0] dl;
    logic [StampBits-1:0] st;
    logic [TASK_BITS-1:0] tk;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_POP, S_POP_LD, S_DN_RDL, S_DN_RDR, S_DN_CMP,
    S_EMIT, S_WAIT
  } state_e;

  ent_t mem_q [HEAP_DEPTH];
  ent_t rd_q;
  logic          we;
  logic [AW-1:0] wa, ra;
  ent_t          wd;

  state_e state_q;
  logic [CW-1:0] cnt_q;
  logic [StampBits-1:0] stamp_q;
  logic [AW-1:0] pos_q;
  ent_t cur_q, lch_q, root_q;
  logic [TIME_BITS-1:0] now_q;
  logic [FW-1:0] nfire_q;
  logic fire_op_q;
  logic hit_q;
  logic ovf_q;
  logic more_q;
  tdh_out_t out_q;
  logic ovalid_q;
  logic [TASK_BITS-1:0] popped_q;

  function automatic logic slot_first(ent_t a, ent_t b);
    if (a.dl != b.dl) return a.dl < b.dl;
    if (a.st != b.st) return a.st < b.st;
    return a.tk < b.tk;
  endfunction

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[ra];
  end

  // Wait until the root deadline given the count after this step.
  function automatic logic [WaitBits-1:0] wait_of(logic [CW-1:0] c, ent_t r,
                                                  logic [TIME_BITS-1:0] now);
    logic [DW-1:0] diff;
    diff = DW'(r.dl) - DW'(now);
    if (c == '0) return WaitEmpty;
    if (r.dl <= now) return '0;
    if (diff > DW'(WaitMax)) return WaitMax;
    return WaitBits'(diff);
  endfunction

  logic [AW:0] lidx, ridx;
  assign lidx = {pos_q, 1'b1};
  assign ridx = {pos_q, 1'b1} + 1'b1;
  logic [AW-1:0] parent;
  assign parent = (pos_q - 1'b1) >> 1;

  logic in_fire;
  assign in_fire = (in_i.operation == OpFire);
  assign in_i.ready = (state_q == S_IDLE);

  // Sift decisions; rd_q holds the parent while rising and the right child
  // while sinking.
  logic up_move, lv, rv, pick_r, dn_move, more;
  ent_t best;
  assign up_move = (pos_q != '0) && slot_first(cur_q, rd_q);
  assign lv      = lidx < (AW+1)'(cnt_q);
  assign rv      = ridx < (AW+1)'(cnt_q);
  assign pick_r  = rv && slot_first(rd_q, lch_q);
  assign best    = pick_r ? rd_q : lch_q;
  assign dn_move = lv && slot_first(best, cur_q);
  assign more    = fire_op_q && (nfire_q < FW'(FireCap)) && (cnt_q != '0) &&
                   (root_q.dl <= now_q);

  // Memory port control.
  always_comb begin
    we = 1'b0; wa = pos_q; wd = cur_q; ra = pos_q;
    unique case (state_q)
      S_UP_RD:  ra = parent;
      S_UP_CMP: begin we = 1'b1; wd = up_move ? rd_q : cur_q; end
      S_POP:    ra = AW'(cnt_q - 1'b1);
      S_DN_RDL: ra = lidx[AW-1:0];
      S_DN_RDR: ra = ridx[AW-1:0];
      S_DN_CMP: begin we = 1'b1; wd = dn_move ? best : cur_q; end
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; stamp_q <= '0; ovalid_q <= 1'b0;
      nfire_q <= '0; fire_op_q <= 1'b0; hit_q <= 1'b0; ovf_q <= 1'b0;
      more_q <= 1'b0; pos_q <= '0; cur_q <= '0; lch_q <= '0; root_q <= '0;
      now_q <= '0; out_q <= '0; popped_q <= '0;
    end else begin
      if (ovalid_q && out_o.ready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_i.valid) begin
          now_q <= in_i.current_time;
          nfire_q <= '0;
          fire_op_q <= in_fire;
          hit_q <= 1'b0;
          ovf_q <= 1'b0;
          if (in_fire) begin
            if (cnt_q != '0 && root_q.dl <= in_i.current_time) state_q <= S_POP;
            else state_q <= S_EMIT;
          end else if (cnt_q >= CW'(HEAP_DEPTH)) begin
            ovf_q <= 1'b1;
            state_q <= S_EMIT;
          end else begin
            cur_q <= '{dl: in_i.deadline, st: stamp_q, tk: in_i.task_id};
            stamp_q <= stamp_q + 1'b1;
            pos_q <= cnt_q[AW-1:0];
            cnt_q <= cnt_q + 1'b1;
            state_q <= S_UP_RD;
          end
        end
        S_UP_RD: state_q <= S_UP_CMP;
        S_UP_CMP: begin
          if (up_move) begin
            pos_q <= parent; state_q <= S_UP_RD;
          end else begin
            if (pos_q == '0) root_q <= cur_q;
            state_q <= S_EMIT;
          end
        end
        S_POP: begin
          popped_q <= root_q.tk;
          hit_q <= 1'b1;
          cnt_q <= cnt_q - 1'b1;
          pos_q <= '0;
          nfire_q <= nfire_q + 1'b1;
          state_q <= (cnt_q == CW'(1)) ? S_EMIT : S_POP_LD;
        end
        // The former last entry restarts at the root and sinks.
        S_POP_LD: begin
          cur_q <= rd_q;
          state_q <= S_DN_RDL;
        end
        S_DN_RDL: state_q <= S_DN_RDR;
        S_DN_RDR: begin
          lch_q <= rd_q;
          state_q <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (dn_move) begin
            if (pos_q == '0) root_q <= best;
            pos_q <= pick_r ? ridx[AW-1:0] : lidx[AW-1:0];
            state_q <= S_DN_RDL;
          end else begin
            if (pos_q == '0) root_q <= cur_q;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          out_q <= '{ready_task: hit_q ? TaskBits'(popped_q) : '0, fired: hit_q,
                     last: !more, wait_ms: wait_of(cnt_q, root_q, now_q),
                     overflow: ovf_q};
          ovalid_q <= 1'b1;
          more_q <= more;
          state_q <= S_WAIT;
        end
        S_WAIT: if (!ovalid_q || out_o.ready) state_q <= more_q ? S_POP : S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid = ovalid_q;
  assign out_o.ready_task = out_q.ready_task;
  assign out_o.fired = out_q.fired;
  assign out_o.last = out_q.last;
  assign out_o.wait_ms = out_q.wait_ms;
  assign out_o.overflow = out_q.overflow;
endmodule
